>>> rtl/pzg_pkg.sv
// shared constants and types of the pinch zoom gesture detector
package pzg_pkg;

   localparam int COORD_BITS = 12;
   localparam int IN_COORD_W = 12;
   localparam int KIND_W     = 2;
   localparam int COUNT_W    = 4;
   localparam int CODE_W     = 2;
   localparam int SPAN_W     = 17;
   localparam int CENTER_W   = 13;
   localparam int HIST_W     = 2;

   // squared distance, then 8 zero bits for 4 fraction bits of the root
   localparam int PROD_W     = 2 * COORD_BITS;
   localparam int SUM_W      = PROD_W + 1;
   localparam int FRAC_SHIFT = 8;
   localparam int RAD_W      = SUM_W + FRAC_SHIFT + 1;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 2;
   localparam int STEP_W     = $clog2(ROOT_W);

   localparam logic [HIST_W-1:0]  HIST_FULL   = 2'd3;
   localparam logic [COUNT_W-1:0] FINGERS_ONE = 4'd1;
   localparam logic [COUNT_W-1:0] FINGERS_TWO = 4'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_DOWN  = 2'd0,
      KIND_MOVE  = 2'd1,
      KIND_UP    = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef enum logic [CODE_W-1:0] {
      CODE_UNKNOWN = 2'd0,
      CODE_BEGIN   = 2'd1,
      CODE_ZOOM    = 2'd2,
      CODE_END     = 2'd3
   } code_type;

endpackage

>>> rtl/pzg_req_if.sv
// touch report channel
interface pzg_req_if;
   logic                          valid;
   logic                          ready;
   logic [pzg_pkg::KIND_W-1:0]    event_kind;
   logic [pzg_pkg::COUNT_W-1:0]   finger_count;
   logic [pzg_pkg::IN_COORD_W-1:0] first_x;
   logic [pzg_pkg::IN_COORD_W-1:0] first_y;
   logic [pzg_pkg::IN_COORD_W-1:0] second_x;
   logic [pzg_pkg::IN_COORD_W-1:0] second_y;

   modport source (
      output valid, event_kind, finger_count, first_x, first_y, second_x, second_y,
      input  ready
   );
   modport sink (
      input  valid, event_kind, finger_count, first_x, first_y, second_x, second_y,
      output ready
   );
endinterface

>>> rtl/pzg_rsp_if.sv
// gesture result channel
interface pzg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pzg_pkg::CODE_W-1:0]    gesture_code;
   logic [pzg_pkg::SPAN_W-1:0]    span;
   logic [pzg_pkg::CENTER_W-1:0]  center_x_half;
   logic [pzg_pkg::CENTER_W-1:0]  center_y_half;

   modport source (
      output valid, gesture_code, span, center_x_half, center_y_half,
      input  ready
   );
   modport sink (
      input  valid, gesture_code, span, center_x_half, center_y_half,
      output ready
   );
endinterface

>>> rtl/pinch_zoom_gesture_detector.sv
// pinch zoom gesture detector: one gesture word per touch report
// two-finger report: one shared multiplier squares dx then dy, then one restoring
//   root step per cycle, then the finish state registers the result
// other reports: straight from idle to the finish state, which registers the result
// req ready only while idle, so a new report is not taken until the last result is registered
// synchronous reset clears the sequencer, the history, the pinch flag, the stored span and center and the result valid
module pinch_zoom_gesture_detector (
   input  logic       clock,
   input  logic       reset,
   pzg_req_if.sink    req_chan,
   pzg_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_FINISH
   } state_type;

   state_type                        state_ff, state_in;
   logic [pzg_pkg::HIST_W-1:0]       hist_ff, hist_in;
   logic                             active_ff, active_in;
   logic [pzg_pkg::SPAN_W-1:0]       prev_span_ff, prev_span_in;
   logic [pzg_pkg::CENTER_W-1:0]     prev_cx_ff, prev_cx_in;
   logic [pzg_pkg::CENTER_W-1:0]     prev_cy_ff, prev_cy_in;
   pzg_pkg::code_type                code_ff, code_in;
   logic [pzg_pkg::SPAN_W-1:0]       span_ff, span_in;
   logic [pzg_pkg::CENTER_W-1:0]     cx_ff, cx_in;
   logic [pzg_pkg::CENTER_W-1:0]     cy_ff, cy_in;
   logic [pzg_pkg::COORD_BITS-1:0]   dx_ff, dx_in;
   logic [pzg_pkg::COORD_BITS-1:0]   dy_ff, dy_in;
   logic [pzg_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [pzg_pkg::RAD_W-1:0]        rad_ff, rad_in;
   logic [pzg_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [pzg_pkg::ROOT_W-1:0]       root_ff, root_in;
   logic [pzg_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pzg_pkg::code_type                rsp_code_ff, rsp_code_in;
   logic [pzg_pkg::SPAN_W-1:0]       rsp_span_ff, rsp_span_in;
   logic [pzg_pkg::CENTER_W-1:0]     rsp_cx_ff, rsp_cx_in;
   logic [pzg_pkg::CENTER_W-1:0]     rsp_cy_ff, rsp_cy_in;

   logic                             accept;
   pzg_pkg::kind_type                kind;
   logic [pzg_pkg::COORD_BITS-1:0]   x0, y0, x1, y1, dx, dy;
   logic [pzg_pkg::HIST_W-1:0]       hist_base, hist_next;
   pzg_pkg::code_type                pair_code;
   logic [pzg_pkg::COORD_BITS-1:0]   mul_a;
   logic [pzg_pkg::PROD_W-1:0]       mul_p;
   logic [pzg_pkg::SUM_W-1:0]        sq_sum;
   logic [pzg_pkg::REM_W-1:0]        rem_sh, trial;
   logic                             trial_ok;
   logic [pzg_pkg::ROOT_W-1:0]       root_step;

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign accept                 = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.gesture_code  = rsp_code_ff;
   assign rsp_chan.span          = rsp_span_ff;
   assign rsp_chan.center_x_half = rsp_cx_ff;
   assign rsp_chan.center_y_half = rsp_cy_ff;

   assign kind = pzg_pkg::kind_type'(req_chan.event_kind);
   assign x0   = pzg_pkg::COORD_BITS'(req_chan.first_x);
   assign y0   = pzg_pkg::COORD_BITS'(req_chan.first_y);
   assign x1   = pzg_pkg::COORD_BITS'(req_chan.second_x);
   assign y1   = pzg_pkg::COORD_BITS'(req_chan.second_y);
   assign dx   = (x0 >= x1) ? (x0 - x1) : (x1 - x0);
   assign dy   = (y0 >= y1) ? (y0 - y1) : (y1 - y0);

   // a one-finger down starts a fresh history
   assign hist_base = (kind == pzg_pkg::KIND_DOWN && req_chan.finger_count == pzg_pkg::FINGERS_ONE)
                      ? '0 : hist_ff;
   assign hist_next = (hist_base == pzg_pkg::HIST_FULL) ? hist_base : hist_base + 1'b1;

   always_comb begin
      unique case (kind)
         pzg_pkg::KIND_DOWN: pair_code = pzg_pkg::CODE_BEGIN;
         pzg_pkg::KIND_MOVE: pair_code = pzg_pkg::CODE_ZOOM;
         pzg_pkg::KIND_UP:   pair_code = pzg_pkg::CODE_END;
         default:            pair_code = pzg_pkg::CODE_UNKNOWN;
      endcase
   end

   // shared squaring unit
   assign mul_a  = (state_ff == ST_SQ_X) ? dx_ff : dy_ff;
   assign mul_p  = mul_a * mul_a;
   assign sq_sum = pzg_pkg::SUM_W'(prod_ff) + pzg_pkg::SUM_W'(mul_p);

   // one restoring root digit
   assign rem_sh    = {rem_ff[pzg_pkg::REM_W-3:0], rad_ff[pzg_pkg::RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign trial_ok  = (rem_sh >= trial);
   assign root_step = {root_ff[pzg_pkg::ROOT_W-2:0], trial_ok};

   always_comb begin
      state_in     = state_ff;
      hist_in      = hist_ff;
      active_in    = active_ff;
      prev_span_in = prev_span_ff;
      prev_cx_in   = prev_cx_ff;
      prev_cy_in   = prev_cy_ff;
      code_in      = code_ff;
      span_in      = span_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in  = rsp_code_ff;
      rsp_span_in  = rsp_span_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hist_in   = hist_next;
               active_in = (req_chan.finger_count == pzg_pkg::FINGERS_TWO)
                           && (kind != pzg_pkg::KIND_UP);
               if (req_chan.finger_count == pzg_pkg::FINGERS_TWO) begin
                  dx_in    = dx;
                  dy_in    = dy;
                  cx_in    = pzg_pkg::CENTER_W'({1'b0, x0} + {1'b0, x1});
                  cy_in    = pzg_pkg::CENTER_W'({1'b0, y0} + {1'b0, y1});
                  code_in  = pair_code;
                  state_in = ST_SQ_X;
               end else begin
                  // one finger lifted after a live pinch ends the zoom
                  if (req_chan.finger_count == pzg_pkg::FINGERS_ONE
                      && hist_next == pzg_pkg::HIST_FULL && active_ff) begin
                     code_in = pzg_pkg::CODE_END;
                     span_in = prev_span_ff;
                     cx_in   = prev_cx_ff;
                     cy_in   = prev_cy_ff;
                  end else begin
                     code_in = pzg_pkg::CODE_UNKNOWN;
                     span_in = '0;
                     cx_in   = '0;
                     cy_in   = '0;
                  end
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SQ_X: begin
            prod_in  = mul_p;
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            rad_in   = {1'b0, sq_sum, {pzg_pkg::FRAC_SHIFT{1'b0}}};
            rem_in   = '0;
            root_in  = '0;
            step_in  = pzg_pkg::STEP_W'(pzg_pkg::ROOT_W - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = trial_ok ? (rem_sh - trial) : rem_sh;
            root_in = root_step;
            rad_in  = {rad_ff[pzg_pkg::RAD_W-3:0], 2'b00};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               span_in      = pzg_pkg::SPAN_W'(root_step);
               prev_span_in = pzg_pkg::SPAN_W'(root_step);
               prev_cx_in   = cx_ff;
               prev_cy_in   = cy_ff;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_span_in  = span_ff;
               rsp_cx_in    = cx_ff;
               rsp_cy_in    = cy_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hist_ff      <= '0;
         active_ff    <= 1'b0;
         prev_span_ff <= '0;
         prev_cx_ff   <= '0;
         prev_cy_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         active_ff    <= active_in;
         prev_span_ff <= prev_span_in;
         prev_cx_ff   <= prev_cx_in;
         prev_cy_ff   <= prev_cy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      span_ff     <= span_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      prod_ff     <= prod_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      rsp_code_ff <= rsp_code_in;
      rsp_span_ff <= rsp_span_in;
      rsp_cx_ff   <= rsp_cx_in;
      rsp_cy_ff   <= rsp_cy_in;
   end

endmodule

>>> rtl/pzg_checker.sv
// port-level checks of the pinch zoom gesture detector, bound to the top level
module pzg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [pzg_pkg::COUNT_W-1:0]      req_finger_count,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pzg_pkg::CODE_W-1:0]       rsp_gesture_code,
   input logic [pzg_pkg::SPAN_W-1:0]       rsp_span,
   input logic [pzg_pkg::CENTER_W-1:0]     rsp_center_x_half,
   input logic [pzg_pkg::CENTER_W-1:0]     rsp_center_y_half
);

   // one report at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("report taken while a report is in progress");

   // non-pinch report taken while the output is free yields a valid result that is never begin or zoom
   a_short_report: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_finger_count != pzg_pkg::FINGERS_TWO
      && (!rsp_valid || rsp_ready)
      |=> ##1 rsp_valid && rsp_gesture_code != pzg_pkg::CODE_BEGIN
          && rsp_gesture_code != pzg_pkg::CODE_ZOOM)
      else $error("short report result late or wrong");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gesture_code)
         && $stable(rsp_span) && $stable(rsp_center_x_half) && $stable(rsp_center_y_half))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result valid or busy after reset");

endmodule

bind pinch_zoom_gesture_detector pzg_checker u_pzg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_finger_count  (req_chan.finger_count),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_gesture_code  (rsp_chan.gesture_code),
   .rsp_span          (rsp_chan.span),
   .rsp_center_x_half (rsp_chan.center_x_half),
   .rsp_center_y_half (rsp_chan.center_y_half)
);

>>> tb/sv/testbench.sv
// self-checking testbench of the pinch zoom gesture detector
module testbench;

   typedef struct packed {
      pzg_pkg::kind_type                kind;
      logic [pzg_pkg::COUNT_W-1:0]      fingers;
      logic [pzg_pkg::IN_COORD_W-1:0]   x0;
      logic [pzg_pkg::IN_COORD_W-1:0]   y0;
      logic [pzg_pkg::IN_COORD_W-1:0]   x1;
      logic [pzg_pkg::IN_COORD_W-1:0]   y1;
   } touch_report_type;

   typedef struct packed {
      pzg_pkg::code_type                code;
      logic [pzg_pkg::SPAN_W-1:0]       span;
      logic [pzg_pkg::CENTER_W-1:0]     cx;
      logic [pzg_pkg::CENTER_W-1:0]     cy;
   } gesture_type;

   class gesture_scoreboard;
      bit [pzg_pkg::HIST_W-1:0]     reports_held;
      bit                           pinch_live;
      bit [pzg_pkg::SPAN_W-1:0]     last_span;
      bit [pzg_pkg::CENTER_W-1:0]   last_cx;
      bit [pzg_pkg::CENTER_W-1:0]   last_cy;
      gesture_type                  gestures_due[$];
      int                           mismatches;

      function new();
         reports_held = '0;
         pinch_live   = 1'b0;
         last_span    = '0;
         last_cx      = '0;
         last_cy      = '0;
         mismatches   = 0;
      endfunction

      // floor of 16 * distance, found one root bit at a time from the top
      function bit [pzg_pkg::SPAN_W-1:0] finger_span(longint unsigned dx, longint unsigned dy);
         longint unsigned scaled;
         longint unsigned root;
         longint unsigned trial;
         scaled = (dx * dx + dy * dy) << 8;
         root = 0;
         for (int b = pzg_pkg::SPAN_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= scaled) root = trial;
         end
         return root[pzg_pkg::SPAN_W-1:0];
      endfunction

      function void note_report(touch_report_type r);
         gesture_type     g;
         longint unsigned dx, dy;
         if (r.kind == pzg_pkg::KIND_DOWN && r.fingers == pzg_pkg::FINGERS_ONE)
            reports_held = '0;
         if (reports_held != pzg_pkg::HIST_FULL) reports_held++;
         g = '{pzg_pkg::CODE_UNKNOWN, '0, '0, '0};
         if (r.fingers == pzg_pkg::FINGERS_TWO) begin
            dx = (r.x0 >= r.x1) ? r.x0 - r.x1 : r.x1 - r.x0;
            dy = (r.y0 >= r.y1) ? r.y0 - r.y1 : r.y1 - r.y0;
            g.span = finger_span(dx, dy);
            g.cx   = {1'b0, r.x0} + {1'b0, r.x1};
            g.cy   = {1'b0, r.y0} + {1'b0, r.y1};
            case (r.kind)
               pzg_pkg::KIND_DOWN: g.code = pzg_pkg::CODE_BEGIN;
               pzg_pkg::KIND_MOVE: g.code = pzg_pkg::CODE_ZOOM;
               pzg_pkg::KIND_UP:   g.code = pzg_pkg::CODE_END;
               default:            g.code = pzg_pkg::CODE_UNKNOWN;
            endcase
            last_span = g.span;
            last_cx   = g.cx;
            last_cy   = g.cy;
         end else if (r.fingers == pzg_pkg::FINGERS_ONE && reports_held == pzg_pkg::HIST_FULL
                      && pinch_live) begin
            g = '{pzg_pkg::CODE_END, last_span, last_cx, last_cy};
         end
         pinch_live = (r.fingers == pzg_pkg::FINGERS_TWO && r.kind != pzg_pkg::KIND_UP);
         gestures_due = {gestures_due, g};
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_gesture(gesture_type got);
         gesture_type want;
         if (gestures_due.size() == 0) begin
            report_mismatch($sformatf("gesture word with none expected, code %0d", got.code));
         end else begin
            want = gestures_due.pop_front();
            if (got.code !== want.code)
               report_mismatch($sformatf("code %0d, expected %0d", got.code, want.code));
            if (got.span !== want.span)
               report_mismatch($sformatf("span %0d, expected %0d", got.span, want.span));
            if (got.cx !== want.cx)
               report_mismatch($sformatf("center x %0d, expected %0d", got.cx, want.cx));
            if (got.cy !== want.cy)
               report_mismatch($sformatf("center y %0d, expected %0d", got.cy, want.cy));
         end
      endtask

      function int pending();
         return gestures_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pzg_req_if req_chan ();
   pzg_rsp_if rsp_chan ();

   pinch_zoom_gesture_detector DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   gesture_scoreboard sb = new();
   int reports_sent = 0;
   int burst_left   = 0;

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_gesture('{pzg_pkg::code_type'(rsp_chan.gesture_code), rsp_chan.span,
                            rsp_chan.center_x_half, rsp_chan.center_y_half});
   end

   // receiver: segments of always ready, coin flips and long stalls
   initial begin
      int mode;
      int left;
      rsp_chan.ready = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(10, 150);
         end
         left--;
         case (mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ($urandom_range(0, 1) == 1);
            default: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   function automatic touch_report_type make_report(pzg_pkg::kind_type k, int n, int ax,
                                                    int ay, int bx, int by);
      touch_report_type r;
      r.kind    = k;
      r.fingers = n[pzg_pkg::COUNT_W-1:0];
      r.x0      = ax[pzg_pkg::IN_COORD_W-1:0];
      r.y0      = ay[pzg_pkg::IN_COORD_W-1:0];
      r.x1      = bx[pzg_pkg::IN_COORD_W-1:0];
      r.y1      = by[pzg_pkg::IN_COORD_W-1:0];
      return r;
   endfunction

   function automatic int rand_coord();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 0;
      if (pick == 1) return (1 << pzg_pkg::IN_COORD_W) - 1;
      return $urandom_range(0, (1 << pzg_pkg::IN_COORD_W) - 1);
   endfunction

   // entered and left at a falling edge; valid stays high within a burst
   task automatic send_report(input touch_report_type r);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.event_kind   <= r.kind;
      req_chan.finger_count <= r.fingers;
      req_chan.first_x      <= r.x0;
      req_chan.first_y      <= r.y0;
      req_chan.second_x     <= r.x1;
      req_chan.second_y     <= r.y1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_report(r);
      reports_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   function automatic touch_report_type two_fingers(pzg_pkg::kind_type k);
      return make_report(k, 2, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   function automatic touch_report_type one_finger(pzg_pkg::kind_type k);
      return make_report(k, 1, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endfunction

   // a well-formed pinch with random content and a random way out
   task automatic run_pinch();
      int moves;
      send_report(one_finger(pzg_pkg::KIND_DOWN));
      send_report(two_fingers(pzg_pkg::KIND_DOWN));
      moves = $urandom_range(0, 8);
      repeat (moves) send_report(two_fingers(pzg_pkg::KIND_MOVE));
      case ($urandom_range(0, 4))
         0: begin
            send_report(two_fingers(pzg_pkg::KIND_UP));
            send_report(one_finger(pzg_pkg::KIND_UP));
         end
         1: send_report(one_finger(pzg_pkg::KIND_MOVE));
         2: send_report(one_finger(pzg_pkg::KIND_UP));
         3: send_report(one_finger(pzg_pkg::KIND_OTHER));
         default: ;
      endcase
   endtask

   task automatic send_noise();
      int n;
      n = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 2);
      send_report(make_report(pzg_pkg::kind_type'($urandom_range(0, 3)), n, rand_coord(),
                              rand_coord(), rand_coord(), rand_coord()));
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.event_kind   = pzg_pkg::KIND_DOWN;
      req_chan.finger_count = '0;
      req_chan.first_x      = '0;
      req_chan.first_y      = '0;
      req_chan.second_x     = '0;
      req_chan.second_y     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // short history after reset: no zoom end yet
      send_report(make_report(pzg_pkg::KIND_MOVE, 2, 10, 20, 30, 40));
      send_report(make_report(pzg_pkg::KIND_MOVE, 1, 5, 5, 0, 0));
      send_report(make_report(pzg_pkg::KIND_DOWN, 1, 100, 200, 4095, 4095));
      send_report(make_report(pzg_pkg::KIND_DOWN, 2, 0, 0, 4095, 4095));
      send_report(make_report(pzg_pkg::KIND_MOVE, 2, 4095, 0, 0, 4095));
      send_report(make_report(pzg_pkg::KIND_MOVE, 1, 4095, 4095, 4095, 4095));
      send_report(make_report(pzg_pkg::KIND_DOWN, 2, 2048, 2048, 2048, 2048));
      // one-finger down after an active pinch clears instead of ending it
      send_report(make_report(pzg_pkg::KIND_DOWN, 1, 0, 0, 0, 0));
      send_report(make_report(pzg_pkg::KIND_DOWN, 2, 'haaa, 'h555, 'h555, 'haaa));
      send_report(make_report(pzg_pkg::KIND_UP, 2, 4095, 4095, 0, 0));
      send_report(make_report(pzg_pkg::KIND_MOVE, 1, 7, 7, 7, 7));
      // other event with two fingers still carries span and center
      send_report(make_report(pzg_pkg::KIND_OTHER, 2, 1, 2, 3, 4));
      send_report(make_report(pzg_pkg::KIND_OTHER, 1, 9, 9, 9, 9));
      send_report(make_report(pzg_pkg::KIND_MOVE, 2, 300, 400, 0, 0));
      send_report(make_report(pzg_pkg::KIND_DOWN, 0, 4095, 4095, 4095, 4095));
      send_report(make_report(pzg_pkg::KIND_UP, 1, 1, 1, 1, 1));
      send_report(make_report(pzg_pkg::KIND_MOVE, 2, 0, 4095, 4095, 0));
      send_report(make_report(pzg_pkg::KIND_MOVE, 15, 4095, 4095, 4095, 4095));
      send_report(make_report(pzg_pkg::KIND_MOVE, 1, 2, 2, 2, 2));
      send_report(make_report(pzg_pkg::KIND_MOVE, 2, 'h555, 'haaa, 'haaa, 'h555));
      send_report(make_report(pzg_pkg::KIND_MOVE, 3, 4095, 0, 4095, 0));
      send_report(make_report(pzg_pkg::KIND_UP, 1, 3, 3, 3, 3));
      send_report(make_report(pzg_pkg::KIND_MOVE, 2, 4095, 4095, 4094, 4094));
      send_report(make_report(pzg_pkg::KIND_UP, 1, 0, 4095, 0, 4095));

      while (reports_sent < 1650) begin
         if ($urandom_range(0, 9) < 7) run_pinch();
         else send_noise();
      end
      req_chan.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> pinch_zoom_gesture_detector.f
rtl/pzg_pkg.sv
rtl/pzg_req_if.sv
rtl/pzg_rsp_if.sv
rtl/pinch_zoom_gesture_detector.sv
rtl/pzg_checker.sv
tb/sv/testbench.sv
